### rtl/crcsc_pkg.sv
// Package for the CRC-32 signature classifier: constants, register map, class codes
// and the byte-wide reflected CRC-32 update. Depends on nothing.
`default_nettype none

package crcsc_pkg;

   localparam int unsigned CRC_W  = 32;
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [CRC_W-1:0] CRC_POLY   = 32'hEDB8_8320;
   localparam logic [CRC_W-1:0] CRC_PRESET = 32'hFFFF_FFFF;

   localparam logic [CRC_W-1:0] SIG_FIRST_RESET  = 32'hC787_5F27;
   localparam logic [CRC_W-1:0] SIG_SECOND_RESET = 32'hBB79_B1B2;
   localparam logic [CRC_W-1:0] SIG_THIRD_RESET  = 32'h3CA0_06E6;

   // Register index within the map; byte address is four times the index.
   localparam logic [1:0] REG_SIG_FIRST  = 2'd0;
   localparam logic [1:0] REG_SIG_SECOND = 2'd1;
   localparam logic [1:0] REG_SIG_THIRD  = 2'd2;

   typedef logic [1:0] class_type;

   localparam class_type CLASS_FIRST  = 2'd0;
   localparam class_type CLASS_SECOND = 2'd1;
   localparam class_type CLASS_THIRD  = 2'd2;

   // One byte through the reflected CRC, least significant bit first.
   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] data);
      logic [CRC_W-1:0] c;
      c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, data};
      for (int i = 0; i < BYTE_W; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

### rtl/crcsc_stream_if.sv
// Valid/ready channel interfaces for the byte stream and the result stream.
// Depends on crcsc_pkg for widths and the class type.
`default_nettype none

interface crcsc_req_if;
   logic                            valid;
   logic                            ready;
   logic [crcsc_pkg::BYTE_W-1:0]    data_byte;
   logic                            last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface crcsc_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [crcsc_pkg::CRC_W-1:0]     crc_value;
   crcsc_pkg::class_type            image_class;

   modport source (output valid, output crc_value, output image_class, input ready);
   modport sink   (input valid, input crc_value, input image_class, output ready);
endinterface

`default_nettype wire

### rtl/crc32_rom_signature_classifier_core.sv
// Channel      | Dir | Payload                          | Handshake
// req          | in  | data_byte[7:0], last_byte        | valid/ready
// rsp          | out | crc_value[31:0], image_class[1:0]| valid/ready
// csr          | in  | APB-style, three 32-bit signature registers at 0x0, 0x4, 0x8
//
// Each byte is held in the input register and updates the CRC as it leaves it; a last
// byte loads the result register on that same edge. One byte is taken every cycle while
// no last byte waits for a full result slot. Synchronous reset empties both registers,
// presets the CRC and restores the signature defaults. A stalled result holds only last
// bytes back: ordinary bytes keep flowing into the CRC while a result waits.
// Depends on crcsc_pkg and crcsc_stream_if.
`default_nettype none

module crc32_rom_signature_classifier_core (
   input  wire                                 clock,
   input  wire                                 reset,
   crcsc_req_if.sink                           req,
   crcsc_rsp_if.source                         rsp,
   input  wire                                 csr_psel,
   input  wire                                 csr_penable,
   input  wire                                 csr_pwrite,
   input  wire [crcsc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire [crcsc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [crcsc_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready
);
   import crcsc_pkg::*;

   logic [CRC_W-1:0]  sig_first_ff, sig_second_ff, sig_third_ff;
   logic [CRC_W-1:0]  crc_ff, crc_in;
   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_last_ff;
   logic              out_valid_ff;
   logic [CRC_W-1:0]  out_crc_ff;
   class_type         out_class_ff;
   logic [CRC_W-1:0]  final_crc;
   class_type         class_in;
   logic              out_free, in_go, csr_write;
   logic [1:0]        csr_index;

   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (csr_index)
         REG_SIG_FIRST:  csr_prdata = sig_first_ff;
         REG_SIG_SECOND: csr_prdata = sig_second_ff;
         REG_SIG_THIRD:  csr_prdata = sig_third_ff;
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sig_first_ff  <= SIG_FIRST_RESET;
         sig_second_ff <= SIG_SECOND_RESET;
         sig_third_ff  <= SIG_THIRD_RESET;
      end else if (csr_write) begin
         if (csr_index == REG_SIG_FIRST)  sig_first_ff  <= csr_pwdata;
         if (csr_index == REG_SIG_SECOND) sig_second_ff <= csr_pwdata;
         if (csr_index == REG_SIG_THIRD)  sig_third_ff  <= csr_pwdata;
      end
   end

   // The input register drains unless it holds a last byte and the result slot is full.
   assign out_free  = !out_valid_ff || rsp.ready;
   assign in_go     = in_valid_ff && (!in_last_ff || out_free);
   assign req.ready = !in_valid_ff || in_go;

   assign crc_in    = crc_byte(crc_ff, in_byte_ff);
   assign final_crc = ~crc_in;

   always_comb begin
      priority if (final_crc == sig_first_ff)  class_in = CLASS_FIRST;
      else if (final_crc == sig_second_ff)     class_in = CLASS_SECOND;
      else if (final_crc == sig_third_ff)      class_in = CLASS_THIRD;
      else                                     class_in = CLASS_FIRST;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         crc_ff       <= CRC_PRESET;
      end else begin
         if (req.ready) begin
            in_valid_ff <= req.valid;
         end
         if (in_go) begin
            crc_ff <= in_last_ff ? CRC_PRESET : crc_in;
         end
         if (in_go && in_last_ff) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         in_byte_ff <= req.data_byte;
         in_last_ff <= req.last_byte;
      end
      if (in_go && in_last_ff) begin
         out_crc_ff   <= final_crc;
         out_class_ff <= class_in;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.crc_value   = out_crc_ff;
   assign rsp.image_class = out_class_ff;

`ifndef SYNTHESIS
   a_preset_after_last: assert property (@(posedge clock) disable iff (reset)
      (in_go && in_last_ff) |=> (crc_ff == CRC_PRESET))
      else $error("CRC not preset after a last byte");

   a_result_after_last: assert property (@(posedge clock) disable iff (reset)
      (in_go && in_last_ff) |=> out_valid_ff)
      else $error("last byte left no result");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (in_go && in_last_ff && out_valid_ff) |-> rsp.ready)
      else $error("pending result overwritten");

   a_stall_holds_crc: assert property (@(posedge clock) disable iff (reset)
      (!in_go && !$past(reset)) |=> $stable(crc_ff))
      else $error("CRC changed without a byte leaving the input register");
`endif

endmodule

`default_nettype wire
